>>> hw/rtl/dbg_pkg.sv
// Package for the density band governor: constants, tables, types.
package dbg_pkg;

    localparam int MaxCrowd = 256;
    localparam int ObsW = 9;
    localparam int SmW = 17;

    typedef enum logic [2:0] {
        CFG_VOICE_LIMIT = 3'd0,
        CFG_RISE_MS     = 3'd1,
        CFG_FALL_MS     = 3'd2,
        CFG_PROMO_HOLD  = 3'd3,
        CFG_DEMO_HOLD   = 3'd4,
        CFG_HYST        = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_EXP,
        ST_EXP2,
        ST_APPLY,
        ST_BAND,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [49:0] dividend;
        logic [16:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [49:0] quotient;
    } div_rsp_t;

    function automatic logic [16:0] exp_int(input logic [2:0] n);
        logic [16:0] r;
        begin
            unique case (n)
                3'd0: r = 17'd65536;
                3'd1: r = 17'd24109;
                3'd2: r = 17'd8869;
                3'd3: r = 17'd3263;
                3'd4: r = 17'd1200;
                3'd5: r = 17'd442;
                3'd6: r = 17'd162;
                default: r = 17'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [16:0] exp_frac(input logic [3:0] i);
        logic [16:0] r;
        begin
            unique case (i)
                4'd0:  r = 17'd65536;
                4'd1:  r = 17'd61565;
                4'd2:  r = 17'd57835;
                4'd3:  r = 17'd54331;
                4'd4:  r = 17'd51039;
                4'd5:  r = 17'd47947;
                4'd6:  r = 17'd45042;
                4'd7:  r = 17'd42313;
                4'd8:  r = 17'd39750;
                4'd9:  r = 17'd37341;
                4'd10: r = 17'd35079;
                4'd11: r = 17'd32954;
                4'd12: r = 17'd30957;
                4'd13: r = 17'd29081;
                4'd14: r = 17'd27319;
                default: r = 17'd25664;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] band_edge(input logic [2:0] b);
        logic [7:0] r;
        begin
            unique case (b)
                3'd0: r = 8'd0;
                3'd1: r = 8'd9;
                3'd2: r = 8'd25;
                3'd3: r = 8'd65;
                default: r = 8'd129;
            endcase
            return r;
        end
    endfunction

    // attacks, spread, active
    function automatic logic [12:0] band_prof(input logic [2:0] b);
        logic [12:0] r;
        begin
            unique case (b)
                3'd0: r = {3'd4, 5'd1, 5'd8};
                3'd1: r = {3'd4, 5'd2, 5'd10};
                3'd2: r = {3'd3, 5'd4, 5'd12};
                3'd3: r = {3'd2, 5'd8, 5'd14};
                default: r = {3'd2, 5'd16, 5'd16};
            endcase
            return r;
        end
    endfunction

endpackage

>>> hw/rtl/dbg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module dbg_div
    import dbg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [49:0] quot_reg, quot_next;
    logic [17:0] rem_reg, rem_next;
    logic [16:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[16:0], quot_reg[49]};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd50;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = trial - {1'b0, dvs_reg};
                quot_next = {quot_reg[48:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[48:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(busy_reg))
        else $error("divider done without busy");
    a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == 6'd0)
        else $error("divider count left over");
    a_done_drops_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> !busy_reg)
        else $error("divider busy at done");
`endif

endmodule

>>> hw/rtl/density_band_governor.sv
// Top level of the density band governor: sequencer, state and output word.
//
//  channel  | handshake            | payload
//  in       | in_valid / in_stall  | held_sources recent_sources time_ms time_valid
//  out      | out_valid / out_stall| observed_density .. profile_changed
//  cfg      | cfg_valid / cfg_ready| cfg_index cfg_data
//
// An item that moves the smoother runs the 50-step serial divide for
// 3*dt*65536/tau (start, 50 quotient bits, done), then exponent, coefficient,
// apply, band and output before the next accept. Other items go from the
// divide state straight to band. rst_n clears all control and governor state.
// A waiting output word holds the next item in the band step.
module density_band_governor
    import dbg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] held_sources,
    input  logic [15:0] recent_sources,
    input  logic [31:0] time_ms,
    input  logic        time_valid,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [8:0]  observed_density,
    output logic [16:0] smoothed_density_q8,
    output logic [2:0]  band_index,
    output logic [2:0]  max_attacks,
    output logic [4:0]  spread_slots,
    output logic [4:0]  max_active,
    output logic        profile_changed,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    state_t state_reg, state_next;

    logic [4:0]  vlim_reg;
    logic [15:0] rise_reg;
    logic [16:0] fall_reg;
    logic [14:0] phold_reg;
    logic [15:0] dhold_reg;
    logic [6:0]  hyst_reg;

    logic [31:0] last_time_reg;
    logic        clk_started_reg, sm_started_reg;
    logic [16:0] sm_reg;
    logic [2:0]  cur_band_reg;
    logic [2:0]  cand_band_reg;
    logic        cand_valid_reg;
    logic [15:0] cand_time_reg;
    logic [12:0] last_prof_reg;

    logic [8:0]  obs_reg;
    logic [9:0]  dt_reg;
    logic        mv_reg;
    logic        up_reg;
    logic [16:0] diff_reg;
    logic [16:0] e_reg;
    logic [11:0] y_reg;
    logic [8:0]  coef_reg;

    logic        ov_reg;
    logic [8:0]  o_obs_reg;
    logic [16:0] o_sm_reg;
    logic [2:0]  o_band_reg;
    logic [12:0] o_prof_reg;
    logic        o_chg_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    dbg_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic        in_acc, out_acc, out_free;
    logic [8:0]  held_c, rec_c, obs_c;
    logic [31:0] dlt;
    logic [9:0]  dt_c;
    logic        has_dt;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = ov_reg && !out_stall;
    assign out_free = !ov_reg || out_acc;
    assign cfg_ready = 1'b1;

    assign held_c = (held_sources > 16'(MaxCrowd)) ? 9'(MaxCrowd) : held_sources[8:0];
    assign rec_c  = (recent_sources > 16'(MaxCrowd)) ? 9'(MaxCrowd) : recent_sources[8:0];
    assign obs_c  = (held_c > rec_c) ? held_c : rec_c;
    assign dlt    = time_ms - last_time_reg;
    assign has_dt = time_valid && clk_started_reg && (time_ms >= last_time_reg)
                    && (dlt != 32'd0);
    assign dt_c   = (dlt > 32'd1000) ? 10'd1000 : dlt[9:0];

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_acc) state_next = ST_DIV;
            ST_DIV:   if (!mv_reg) state_next = ST_BAND;
                      else if (drsp.done) state_next = ST_EXP;
            ST_EXP:   state_next = ST_EXP2;
            ST_EXP2:  state_next = ST_APPLY;
            ST_APPLY: state_next = ST_BAND;
            ST_BAND:  if (out_free) state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    logic div_kick_reg;
    always_comb
    begin
        dreq.start    = div_kick_reg;
        dreq.divisor  = up_reg ? {1'b0, rise_reg} : fall_reg;
        dreq.dividend = 50'(({40'd0, dt_reg} * 50'd3) << 16);
    end

    // exponent path pieces
    logic [49:0] xq;
    logic [33:0] prod1;
    logic [28:0] prod2;
    logic [16:0] e1, e2;
    logic [25:0] mstep;
    logic [16:0] stp;
    logic [17:0] sm_new;
    logic        demote_ok;
    logic [2:0]  tb, desired;
    logic [15:0] hold;
    logic [8:0]  rnd;
    logic [16:0] edge_sc;
    logic [16:0] ct_sum;

    assign xq    = drsp.quotient;
    assign prod1 = {17'd0, exp_int(xq[18:16])} * {17'd0, exp_frac(xq[15:12])};
    assign e1    = 17'((prod1 + 34'd32768) >> 16);
    assign prod2 = {12'd0, e_reg} * {17'd0, y_reg};
    assign e2    = e_reg - 17'((prod2 + 29'd32768) >> 16);
    assign mstep = {17'd0, coef_reg} * {9'd0, diff_reg};
    assign stp   = 17'((mstep + 26'd128) >> 8);
    assign sm_new = up_reg ? ({1'b0, sm_reg} + {1'b0, stp}) : ({1'b0, sm_reg} - {1'b0, stp});

    assign rnd = ((sm_reg + 17'd128) >> 8) > 17'(MaxCrowd) ? 9'(MaxCrowd)
                 : 9'((sm_reg + 17'd128) >> 8);
    always_comb
    begin
        priority if (rnd <= 9'd8)   tb = 3'd0;
        else if (rnd <= 9'd24)      tb = 3'd1;
        else if (rnd <= 9'd64)      tb = 3'd2;
        else if (rnd <= 9'd128)     tb = 3'd3;
        else                        tb = 3'd4;
    end
    assign edge_sc   = 17'({9'd0, band_edge(cur_band_reg)} * (17'd256 - {10'd0, hyst_reg}));
    assign demote_ok = sm_reg < edge_sc;
    always_comb
    begin
        desired = cur_band_reg;
        hold    = '0;
        if (tb > cur_band_reg)
        begin
            desired = tb;
            hold    = {1'b0, phold_reg};
        end
        else if (tb < cur_band_reg && demote_ok)
        begin
            desired = tb;
            hold    = dhold_reg;
        end
    end
    assign ct_sum = {1'b0, cand_time_reg} + {7'd0, dt_reg};

    logic [2:0]  nb;
    logic [12:0] np;
    always_comb
    begin
        nb = cur_band_reg;
        if (desired != cur_band_reg)
        begin
            if (!cand_valid_reg || cand_band_reg != desired)
            begin
                if (hold == 16'd0) nb = desired;
            end
            else if (hold == 16'd0 || (ct_sum > 17'd60000 ? 17'd60000 : ct_sum)
                     >= {1'b0, hold})
                nb = desired;
        end
        np = band_prof(nb);
        if (np[4:0] > vlim_reg) np[4:0] = vlim_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            vlim_reg        <= 5'd16;
            rise_reg        <= 16'd500;
            fall_reg        <= 17'd6000;
            phold_reg       <= 15'd500;
            dhold_reg       <= 16'd4000;
            hyst_reg        <= 7'd51;
            last_time_reg   <= '0;
            clk_started_reg <= 1'b0;
            sm_started_reg  <= 1'b0;
            sm_reg          <= '0;
            cur_band_reg    <= '0;
            cand_band_reg   <= '0;
            cand_valid_reg  <= 1'b0;
            cand_time_reg   <= '0;
            last_prof_reg   <= band_prof(3'd0);
            ov_reg          <= 1'b0;
            div_kick_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            div_kick_reg <= 1'b0;
            if (state_reg == ST_OUT) ov_reg <= 1'b1;
            else if (out_acc) ov_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_VOICE_LIMIT: vlim_reg <= (cfg_data[4:0] < 5'd1) ? 5'd1 :
                        (cfg_data[4:0] > 5'd16) ? 5'd16 : cfg_data[4:0];
                    CFG_RISE_MS: rise_reg <= (cfg_data[15:0] < 16'd50) ? 16'd50 :
                        (cfg_data[15:0] > 16'd60000) ? 16'd60000 : cfg_data[15:0];
                    CFG_FALL_MS: fall_reg <= (cfg_data[16:0] < 17'd50) ? 17'd50 :
                        (cfg_data[16:0] > 17'd120000) ? 17'd120000 : cfg_data[16:0];
                    CFG_PROMO_HOLD: phold_reg <= (cfg_data[14:0] > 15'd30000) ?
                        15'd30000 : cfg_data[14:0];
                    CFG_DEMO_HOLD: dhold_reg <= (cfg_data[15:0] > 16'd60000) ?
                        16'd60000 : cfg_data[15:0];
                    CFG_HYST: hyst_reg <= (cfg_data[6:0] > 7'd125) ? 7'd125 : cfg_data[6:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                    if (in_acc)
                    begin
                        if (time_valid)
                        begin
                            clk_started_reg <= 1'b1;
                            last_time_reg   <= time_ms;
                        end
                        if (!sm_started_reg)
                        begin
                            // first sample loads directly
                            sm_reg         <= {obs_c, 8'd0};
                            sm_started_reg <= 1'b1;
                        end
                        else if (has_dt && ({obs_c, 8'd0} != sm_reg))
                            div_kick_reg <= 1'b1;
                    end
                ST_EXP:
                    ;
                ST_APPLY:
                    sm_reg <= (sm_new > 18'(MaxCrowd * 256)) ? 17'(MaxCrowd * 256)
                              : sm_new[16:0];
                ST_BAND:
                    // hold here until the output register is free
                    if (out_free)
                    begin
                        cur_band_reg <= nb;
                        if (desired == cur_band_reg || nb == desired)
                        begin
                            cand_valid_reg <= 1'b0;
                            cand_band_reg  <= '0;
                            cand_time_reg  <= '0;
                        end
                        else if (!cand_valid_reg || cand_band_reg != desired)
                        begin
                            cand_valid_reg <= 1'b1;
                            cand_band_reg  <= desired;
                            cand_time_reg  <= '0;
                        end
                        else
                            cand_time_reg <= (ct_sum > 17'd60000) ? 16'd60000 : ct_sum[15:0];
                        last_prof_reg <= np;
                        o_prof_reg    <= np;
                        o_band_reg    <= nb;
                        o_chg_reg     <= (np != last_prof_reg);
                        o_obs_reg     <= obs_reg;
                        o_sm_reg      <= sm_reg;
                    end
                default: ;
            endcase
        end
    end

    // datapath working registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            obs_reg <= obs_c;
            dt_reg  <= has_dt ? dt_c : 10'd0;
            mv_reg  <= has_dt && sm_started_reg && ({obs_c, 8'd0} != sm_reg);
            up_reg  <= ({obs_c, 8'd0} >= sm_reg);
            diff_reg <= ({obs_c, 8'd0} >= sm_reg) ? ({obs_c, 8'd0} - sm_reg)
                                                  : (sm_reg - {obs_c, 8'd0});
        end
        if (state_reg == ST_EXP)
        begin
            e_reg <= e1;
            y_reg <= xq[11:0];
        end
        if (state_reg == ST_EXP2)
        begin
            if (xq >= 50'(7 * 65536))
                coef_reg <= 9'd256;
            else
                coef_reg <= 9'((17'd65536 - (e2 > 17'd65536 ? 17'd65536 : e2)
                               + 17'd128) >> 8);
        end
    end

    assign out_valid           = ov_reg;
    assign observed_density    = o_obs_reg;
    assign smoothed_density_q8 = o_sm_reg;
    assign band_index          = o_band_reg;
    assign max_attacks         = o_prof_reg[12:10];
    assign spread_slots        = o_prof_reg[9:5];
    assign max_active          = o_prof_reg[4:0];
    assign profile_changed     = o_chg_reg;

`ifndef ASSERT_OFF
    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_band_reg <= 3'd4)
        else $error("band out of range");
    a_sm_cap: assert property (@(posedge clk) disable iff (!rst_n)
        sm_reg <= 17'(MaxCrowd * 256))
        else $error("smoother above cap");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.busy |-> in_stall)
        else $error("input open while divider runs");
    a_cap_active: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> max_active <= vlim_reg || $past(cfg_valid))
        else $error("active above limit");
`endif

endmodule

>>> tb/density_band_governor_checker.sv
`timescale 1ns / 100ps
// Checker for the density band governor: predicts each result word and compares it.
module density_band_governor_checker
    import dbg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] held_sources,
    input  logic [15:0] recent_sources,
    input  logic [31:0] time_ms,
    input  logic        time_valid,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [8:0]  observed_density,
    input  logic [16:0] smoothed_density_q8,
    input  logic [2:0]  band_index,
    input  logic [2:0]  max_attacks,
    input  logic [4:0]  spread_slots,
    input  logic [4:0]  max_active,
    input  logic        profile_changed,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [8:0]  obs;
        logic [16:0] smooth;
        logic [2:0]  band;
        logic [2:0]  attacks;
        logic [4:0]  spread;
        logic [4:0]  active;
        logic        changed;
    } gov_word_t;

    gov_word_t expected_words[$];

    int unsigned voice_cap, rise_tau, fall_tau, promo_hold, demo_hold, hyst;
    int unsigned prev_stamp, smooth_q8, band_now, cand_band, cand_ms;
    bit          stamp_seen, smooth_seen, cand_live;
    int unsigned prev_prof[4];

    localparam int unsigned ExpWhole[7] = '{65536, 24109, 8869, 3263, 1200, 442, 162};
    localparam int unsigned ExpFrac[16] = '{65536, 61565, 57835, 54331, 51039, 47947,
        45042, 42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
    localparam int unsigned BandLow[5] = '{0, 9, 25, 65, 129};
    localparam int unsigned BandProf[5][4] = '{'{0, 4, 1, 8}, '{1, 4, 2, 10},
        '{2, 3, 4, 12}, '{3, 2, 8, 14}, '{4, 2, 16, 16}};

    function automatic int unsigned clamp(longint unsigned v, int unsigned lo,
                                          int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic int unsigned blend_coef(int unsigned dt, int unsigned tau);
        longint unsigned xq, e;
        xq = (64'd3 * dt * 64'd65536) / tau;
        if (xq >= (64'd7 << 16)) return 256;
        e = (64'(ExpWhole[xq >> 16]) * ExpFrac[(xq >> 12) & 15] + 32768) >> 16;
        e = e - ((e * (xq & 64'hFFF) + 32768) >> 16);
        if (e > 65536) e = 65536;
        return int'((65536 - e + 128) >> 8);
    endfunction

    function automatic int unsigned band_of(int unsigned d);
        if (d <= 8) return 0;
        if (d <= 24) return 1;
        if (d <= 64) return 2;
        if (d <= 128) return 3;
        return 4;
    endfunction

    function automatic gov_word_t govern(int unsigned held, int unsigned recent,
                                         int unsigned stamp, bit stamp_ok);
        gov_word_t w;
        int unsigned obs, dt, target, c, rnd, tb, want, hold;
        int unsigned prof[4];
        bit chg;
        obs = clamp(held, 0, MaxCrowd);
        if (clamp(recent, 0, MaxCrowd) > obs) obs = clamp(recent, 0, MaxCrowd);
        dt = 0;
        hold = 0;
        chg = 0;
        if (stamp_ok) begin
            if (stamp_seen && stamp >= prev_stamp)
                dt = (stamp - prev_stamp > 1000) ? 1000 : stamp - prev_stamp;
            stamp_seen = 1;
            prev_stamp = stamp;
        end
        target = obs << 8;
        if (!smooth_seen) begin
            smooth_q8 = target;
            smooth_seen = 1;
        end else if (dt > 0) begin
            if (target >= smooth_q8) begin
                c = blend_coef(dt, rise_tau);
                smooth_q8 += int'((64'(c) * (target - smooth_q8) + 128) >> 8);
            end else begin
                c = blend_coef(dt, fall_tau);
                smooth_q8 -= int'((64'(c) * (smooth_q8 - target) + 128) >> 8);
            end
            if (smooth_q8 > MaxCrowd * 256) smooth_q8 = MaxCrowd * 256;
        end
        rnd = clamp((smooth_q8 + 128) >> 8, 0, MaxCrowd);
        tb = band_of(rnd);
        want = band_now;
        if (tb > band_now) begin
            want = tb;
            hold = promo_hold;
        end else if (tb < band_now && smooth_q8 < BandLow[band_now] * (256 - hyst)) begin
            want = tb;
            hold = demo_hold;
        end
        if (want == band_now) begin
            cand_live = 0;
            cand_band = 0;
            cand_ms = 0;
        end else begin
            if (!cand_live || cand_band != want) begin
                cand_live = 1;
                cand_band = want;
                cand_ms = 0;
            end else begin
                cand_ms += dt;
                if (cand_ms > 60000) cand_ms = 60000;
            end
            if (hold == 0 || cand_ms >= hold) begin
                band_now = want;
                cand_live = 0;
                cand_band = 0;
                cand_ms = 0;
            end
        end
        for (int k = 0; k < 4; k++) prof[k] = BandProf[band_now][k];
        if (prof[3] > voice_cap) prof[3] = voice_cap;
        for (int k = 0; k < 4; k++) begin
            if (prof[k] != prev_prof[k]) chg = 1;
            prev_prof[k] = prof[k];
        end
        w.obs = 9'(obs);
        w.smooth = 17'(smooth_q8);
        w.band = 3'(prof[0]);
        w.attacks = 3'(prof[1]);
        w.spread = 5'(prof[2]);
        w.active = 5'(prof[3]);
        w.changed = chg;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        gov_word_t got, want;
        if (!rst_n) begin
            voice_cap <= 16; rise_tau <= 500; fall_tau <= 6000;
            promo_hold <= 500; demo_hold <= 4000; hyst <= 51;
            prev_stamp = 0; stamp_seen = 0; smooth_seen = 0; smooth_q8 = 0;
            band_now = 0; cand_band = 0; cand_live = 0; cand_ms = 0;
            prev_prof = '{0, 4, 1, 8};
            expected_words.delete();
            fail_count <= 0;
            pending_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_VOICE_LIMIT: voice_cap <= clamp(cfg_data & 32'h1F, 1, 16);
                    CFG_RISE_MS:     rise_tau <= clamp(cfg_data & 32'hFFFF, 50, 60000);
                    CFG_FALL_MS:     fall_tau <= clamp(cfg_data & 32'h1FFFF, 50, 120000);
                    CFG_PROMO_HOLD:  promo_hold <= clamp(cfg_data & 32'h7FFF, 0, 30000);
                    CFG_DEMO_HOLD:   demo_hold <= clamp(cfg_data & 32'hFFFF, 0, 60000);
                    CFG_HYST:        hyst <= clamp(cfg_data & 32'h7F, 0, 125);
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_words.push_back(govern(held_sources, recent_sources, time_ms,
                                                time_valid));
            if (out_valid && !out_stall) begin
                got = {observed_density, smoothed_density_q8, band_index, max_attacks,
                       spread_slots, max_active, profile_changed};
                if (expected_words.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result word %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("result word differs: exp obs=%0d sm=%0d band=%0d att=%0d spr=%0d act=%0d chg=%0d, got obs=%0d sm=%0d band=%0d att=%0d spr=%0d act=%0d chg=%0d",
                                want.obs, want.smooth, want.band, want.attacks, want.spread,
                                want.active, want.changed, got.obs, got.smooth, got.band,
                                got.attacks, got.spread, got.active, got.changed);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= expected_words.size();
        end
    end

endmodule

>>> tb/density_band_governor_tb.sv
`timescale 1ns / 100ps
// Testbench top for the density band governor: stimulus, stalls and verdict.
module density_band_governor_tb
    import dbg_pkg::*;
();

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [15:0] held_sources = 0;
    logic [15:0] recent_sources = 0;
    logic [31:0] time_ms = 0;
    logic        time_valid = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [8:0]  observed_density;
    logic [16:0] smoothed_density_q8;
    logic [2:0]  band_index;
    logic [2:0]  max_attacks;
    logic [4:0]  spread_slots;
    logic [4:0]  max_active;
    logic        profile_changed;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 0;
    logic [31:0] cfg_data = 0;
    int          fail_count, pending_count;

    bit          idle_free = 0;
    bit          hold_off = 0;
    logic [31:0] stamp_now = 0;

    always #10 clk = ~clk;

    density_band_governor dut (.*);
    density_band_governor_checker checker_i (.*);

    function automatic bit idle_roll();
        return !idle_free && $urandom_range(99) < 31;
    endfunction

    // receiver: random stalls, with a long hold-off on request
    always @(posedge clk) begin
        if (hold_off) out_stall <= 1;
        else out_stall <= idle_roll();
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    task automatic send_word(logic [15:0] held, logic [15:0] recent, logic [31:0] stamp,
                             logic stamp_ok);
        while (idle_roll()) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        held_sources <= held;
        recent_sources <= recent;
        time_ms <= stamp;
        time_valid <= stamp_ok;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending_count != 0 || out_valid) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // mostly modest counts with forward time steps; sometimes noise
    task automatic random_word();
        logic [15:0] held, recent;
        int unsigned r;
        r = $urandom_range(99);
        held = (r < 10) ? 16'($urandom) : 16'($urandom_range(300));
        recent = (r < 20) ? 16'($urandom) : 16'($urandom_range(140));
        if (r < 4) stamp_now = $urandom;
        else if (r < 8) stamp_now = stamp_now - $urandom_range(500);
        else stamp_now = stamp_now + $urandom_range(1300);
        send_word(held, recent, stamp_now, $urandom_range(9) != 0);
    endtask

    initial begin
        #200000000;
        $display("density_band_governor: mismatch");
        $finish;
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: field extremes, first sample, backwards step, invalid stamp
        send_word(16'hFFFF, 0, 32'hFFFF_FFFF, 1);
        send_word(0, 16'hFFFF, 32'hFFFF_FFFF, 1);
        send_word(0, 0, 0, 1);
        send_word(5, 3, 100, 1);
        send_word(200, 300, 600, 0);
        send_word(200, 300, 5000, 1);
        send_word(256, 257, 5400, 1);
        send_word(130, 0, 5401, 1);
        send_word(0, 0, 6401, 1);
        send_word(0, 0, 7401, 1);
        send_word(0, 0, 7401, 1);
        send_word(16'h5555, 16'hAAAA, 32'h5555_5555, 1);
        send_word(16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 1);
        drain();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_VOICE_LIMIT, 0); write_reg(CFG_RISE_MS, 0);
                    write_reg(CFG_FALL_MS, 0); write_reg(CFG_PROMO_HOLD, 0);
                    write_reg(CFG_DEMO_HOLD, 0); write_reg(CFG_HYST, 0);
                end
                1: begin
                    write_reg(CFG_VOICE_LIMIT, 32'hFFFF_FFFF);
                    write_reg(CFG_RISE_MS, 32'hFFFF);
                    write_reg(CFG_FALL_MS, 32'h1FFFF);
                    write_reg(CFG_PROMO_HOLD, 32'h7FFF);
                    write_reg(CFG_DEMO_HOLD, 32'hFFFF);
                    write_reg(CFG_HYST, 32'h7F);
                end
                2: begin
                    write_reg(CFG_VOICE_LIMIT, 16); write_reg(CFG_RISE_MS, 500);
                    write_reg(CFG_FALL_MS, 6000); write_reg(CFG_PROMO_HOLD, 500);
                    write_reg(CFG_DEMO_HOLD, 4000); write_reg(CFG_HYST, 51);
                    write_reg(cfg_idx_t'(3'd7), 5);
                end
                default: begin
                    write_reg(CFG_VOICE_LIMIT, $urandom_range(31));
                    write_reg(CFG_RISE_MS, $urandom_range(3000));
                    write_reg(CFG_FALL_MS, $urandom_range(8000));
                    write_reg(CFG_PROMO_HOLD, $urandom_range(2000));
                    write_reg(CFG_DEMO_HOLD, $urandom_range(3000));
                    write_reg(CFG_HYST, $urandom);
                end
            endcase
            idle_free = (phase == 3);
            for (int n = 0; n < 320; n++) begin
                if (phase == 4 && n == 40) begin
                    fork
                        begin
                            hold_off = 1;
                            repeat (600) @(posedge clk);
                            hold_off = 0;
                        end
                    join_none
                end
                random_word();
            end
            idle_free = 0;
            drain();
        end
        if (fail_count == 0)
            $display("density_band_governor: match");
        else
            $display("density_band_governor: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/dbg_pkg.sv
hw/rtl/dbg_div.sv
hw/rtl/density_band_governor.sv
tb/density_band_governor_checker.sv
tb/density_band_governor_tb.sv
